>>> rtl/eep_pkg.sv
// Shared types and constants of the data EEPROM controller.
// No dependencies; the controller, datapath, top level and checker use it.
package eep_pkg;

   localparam int OP_W      = 2;
   localparam int SEL_W     = 3;
   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 10;
   localparam int ADDR_LO_W = 8;
   localparam int ADDR_HI_W = ADDR_W - ADDR_LO_W;
   localparam int TICKS_W   = 12;
   localparam int STAGE_W   = 2;

   // bus operations
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // register map
   localparam logic [SEL_W-1:0] REG_ADDR_LO = 3'd0;
   localparam logic [SEL_W-1:0] REG_ADDR_HI = 3'd1;
   localparam logic [SEL_W-1:0] REG_DATA    = 3'd2;
   localparam logic [SEL_W-1:0] REG_CONTROL = 3'd3;
   localparam logic [SEL_W-1:0] REG_UNLOCK  = 3'd4;

   // control register bits
   localparam logic [BYTE_W-1:0] CTL_EEPGD  = 8'h80;
   localparam logic [BYTE_W-1:0] CTL_CFGS   = 8'h40;
   localparam logic [BYTE_W-1:0] CTL_FREE   = 8'h10;
   localparam logic [BYTE_W-1:0] CTL_WREN   = 8'h04;
   localparam logic [BYTE_W-1:0] CTL_WR     = 8'h02;
   localparam logic [BYTE_W-1:0] CTL_RD     = 8'h01;
   localparam logic [BYTE_W-1:0] CTL_STORED = CTL_EEPGD | CTL_CFGS | CTL_FREE | CTL_WREN;
   localparam logic [BYTE_W-1:0] CTL_SPACE  = CTL_EEPGD | CTL_CFGS;

   // unlock sequence
   localparam logic [BYTE_W-1:0]  UNLOCK_KEY_FIRST  = 8'h55;
   localparam logic [BYTE_W-1:0]  UNLOCK_KEY_SECOND = 8'hAA;
   localparam logic [STAGE_W-1:0] UNLOCK_IDLE       = 2'd0;
   localparam logic [STAGE_W-1:0] UNLOCK_HALF       = 2'd1;
   localparam logic [STAGE_W-1:0] UNLOCK_ARMED      = 2'd2;

   localparam logic [BYTE_W-1:0]  ERASED_BYTE = 8'hFF;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 12'd64;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [SEL_W-1:0]  register_select;
      logic [BYTE_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              write_busy;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_write;
      logic apply_item;
      logic finish_read;
   } eep_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic read_needed;
      logic clear_last;
   } eep_status_type;

endpackage

>>> rtl/eep_stream_if.sv
// Valid/ready channel carrying one word of a configurable payload type.
// No dependencies.
interface eep_stream_if #(parameter type PAYLOAD_TYPE = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/eep_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module eep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/eep_controller.sv
// Sequencing state machine: erase sweep, item acceptance, cell read wait.
// Depends on eep_pkg.
module eep_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  eep_pkg::eep_status_type status,
   output eep_pkg::eep_cmd_type    cmd
);
   import eep_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_RDWAIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ready          = !rsp_valid_ff || rsp_ready;
            cmd.apply_item = req_valid && ready;
            if (cmd.apply_item && status.read_needed) begin
               state_in = ST_RDWAIT;
            end
         end
         ST_RDWAIT: begin
            cmd.finish_read = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if ((cmd.apply_item && !status.read_needed) || cmd.finish_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = ready;
   assign rsp_valid = rsp_valid_ff;
endmodule

>>> rtl/eep_datapath.sv
// Register file, unlock tracker, write cycle counter and the cell array.
// Depends on eep_pkg and eep_ram.
module eep_datapath #(
   parameter int CELL_COUNT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  eep_pkg::eep_cmd_type             cmd,
   output eep_pkg::eep_status_type          status,
   input  eep_pkg::req_type                 req_word,
   input  logic                             csr_valid,
   input  logic [eep_pkg::TICKS_W-1:0]      csr_value,
   output eep_pkg::rsp_type                 rsp_word
);
   import eep_pkg::*;

   localparam int IDX_W     = $clog2(CELL_COUNT);
   localparam int MOD_W     = (IDX_W >= ADDR_W) ? IDX_W + 1 : ADDR_W + 1;
   localparam int MOD_STEPS = ((1 << ADDR_W) - 1) / CELL_COUNT;

   // fold a bus address onto the cell array
   function automatic logic [IDX_W-1:0] cell_index(input logic [ADDR_W-1:0] addr);
      logic [MOD_W-1:0] v;
      v = MOD_W'(addr);
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (v >= MOD_W'(CELL_COUNT)) begin
            v = v - MOD_W'(CELL_COUNT);
         end
      end
      return v[IDX_W-1:0];
   endfunction

   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic [BYTE_W-1:0]  ctrl_ff, ctrl_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [TICKS_W-1:0] busy_ff, busy_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [BYTE_W-1:0]  pend_byte_ff, pend_byte_in;
   logic               start_ff, start_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   rsp_type            rsp_ff, rsp_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr, ram_raddr;
   logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

   logic [OP_W-1:0]    op;
   logic [SEL_W-1:0]   sel;
   logic [BYTE_W-1:0]  wd;
   logic               ctrl_write, mem_selected, read_cell, can_start;
   logic [TICKS_W-1:0] cycle_len;
   logic [BYTE_W-1:0]  rd_value;

   assign op  = req_word.operation;
   assign sel = req_word.register_select;
   assign wd  = req_word.write_data;

   assign ctrl_write   = (op == OP_WRITE) && (sel == REG_CONTROL);
   assign mem_selected = (wd & CTL_SPACE) == '0;
   assign read_cell    = ctrl_write && ((wd & CTL_RD) != '0) && mem_selected;
   assign can_start    = ctrl_write && ((wd & CTL_WR) != '0) && ((wd & CTL_WREN) != '0)
                         && mem_selected && (stage_ff == UNLOCK_ARMED) && (busy_ff == '0);
   assign cycle_len    = (ticks_ff == '0) ? TICKS_W'(1) : ticks_ff;

   always_comb begin
      case (sel)
         REG_ADDR_LO: rd_value = addr_ff[ADDR_LO_W-1:0];
         REG_ADDR_HI: rd_value = BYTE_W'(addr_ff[ADDR_W-1:ADDR_LO_W]);
         REG_DATA:    rd_value = data_ff;
         REG_CONTROL: rd_value = (ctrl_ff & CTL_STORED) | ((busy_ff != '0) ? CTL_WR : '0);
         default:     rd_value = '0;
      endcase
   end

   always_comb begin
      addr_in      = addr_ff;
      data_in      = data_ff;
      ctrl_in      = ctrl_ff;
      stage_in     = stage_ff;
      busy_in      = busy_ff;
      pend_addr_in = pend_addr_ff;
      pend_byte_in = pend_byte_ff;
      start_in     = start_ff;
      clr_idx_in   = clr_idx_ff;
      rsp_in       = rsp_ff;
      ticks_in     = csr_valid ? csr_value : ticks_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_idx_ff;
      ram_wdata    = ERASED_BYTE;

      if (cmd.clear_write) begin
         ram_we     = 1'b1;
         clr_idx_in = clr_idx_ff + IDX_W'(1);
      end

      if (cmd.apply_item) begin
         case (op)
            OP_WRITE: begin
               case (sel)
                  REG_ADDR_LO: addr_in = {addr_ff[ADDR_W-1:ADDR_LO_W], wd};
                  REG_ADDR_HI: addr_in = {wd[ADDR_HI_W-1:0], addr_ff[ADDR_LO_W-1:0]};
                  REG_DATA:    data_in = wd;
                  REG_CONTROL: begin
                     ctrl_in  = wd & CTL_STORED;
                     stage_in = UNLOCK_IDLE;
                     // a cell read in the same word feeds the captured byte, so defer
                     if (can_start && read_cell) begin
                        start_in = 1'b1;
                     end else if (can_start) begin
                        pend_addr_in = addr_ff;
                        pend_byte_in = data_ff;
                        busy_in      = cycle_len;
                     end
                  end
                  REG_UNLOCK: begin
                     if (wd == UNLOCK_KEY_FIRST) begin
                        stage_in = UNLOCK_HALF;
                     end else if (wd == UNLOCK_KEY_SECOND && stage_ff == UNLOCK_HALF) begin
                        stage_in = UNLOCK_ARMED;
                     end else begin
                        stage_in = UNLOCK_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            OP_TICK: begin
               if (busy_ff != '0) begin
                  busy_in = busy_ff - TICKS_W'(1);
                  if (busy_ff == TICKS_W'(1)) begin
                     ram_we    = 1'b1;
                     ram_waddr = cell_index(pend_addr_ff);
                     ram_wdata = pend_byte_ff;
                  end
               end
            end
            default: begin
            end
         endcase
         rsp_in.read_data  = (op == OP_READ) ? rd_value : '0;
         rsp_in.write_busy = busy_in != '0;
      end

      if (cmd.finish_read) begin
         data_in  = ram_rdata;
         start_in = 1'b0;
         if (start_ff) begin
            pend_addr_in = addr_ff;
            pend_byte_in = ram_rdata;
            busy_in      = cycle_len;
         end
         rsp_in.read_data  = '0;
         rsp_in.write_busy = busy_in != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         data_ff      <= '0;
         ctrl_ff      <= '0;
         stage_ff     <= UNLOCK_IDLE;
         busy_ff      <= '0;
         ticks_ff     <= TICKS_RESET;
         pend_addr_ff <= '0;
         pend_byte_ff <= '0;
         start_ff     <= 1'b0;
         clr_idx_ff   <= '0;
      end else begin
         addr_ff      <= addr_in;
         data_ff      <= data_in;
         ctrl_ff      <= ctrl_in;
         stage_ff     <= stage_in;
         busy_ff      <= busy_in;
         ticks_ff     <= ticks_in;
         pend_addr_ff <= pend_addr_in;
         pend_byte_ff <= pend_byte_in;
         start_ff     <= start_in;
         clr_idx_ff   <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign ram_raddr = cell_index(addr_ff);

   eep_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign status.read_needed = read_cell;
   assign status.clear_last  = clr_idx_ff == IDX_W'(CELL_COUNT - 1);
   assign rsp_word           = rsp_ff;
endmodule

>>> rtl/data_eeprom_controller.sv
// Data EEPROM controller top level: register bus words and ticks in, one result word out.
// The result is registered and valid in the cycle after accept; a cell-reading control word
// first passes the read wait state. Throughput: one word per cycle while results are taken;
// a cell-reading control word holds the input while the single RAM read port returns data.
// Reset (synchronous, active high) clears all registers but the result word, then sweeps
// every cell writing 0xFF into it; no word is accepted during the sweep, csr writes are.
// Depends on eep_pkg, eep_stream_if, eep_controller and eep_datapath.
module data_eeprom_controller #(
   parameter int CELL_COUNT = 1024   // 256 .. 4096 cells
) (
   input logic           clock,
   input logic           reset,
   eep_stream_if.sink    req,
   eep_stream_if.source  rsp,
   eep_stream_if.sink    csr
);
   import eep_pkg::*;

   eep_cmd_type    cmd;
   eep_status_type status;
   req_type        req_word;
   rsp_type        rsp_word;
   logic           req_ready;
   logic           rsp_valid;

   // the cycle length register takes a write at any time
   assign csr.ready = 1'b1;

   assign req_word  = req.payload;
   assign req.ready = req_ready;

   // drive the result channel straight from the output register
   assign rsp.valid   = rsp_valid;
   assign rsp.payload = rsp_word;

   // sequencing: erase sweep, accept, wait on the cell read
   eep_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, unlock sequence, write cycle countdown and cell array
   eep_datapath #(
      .CELL_COUNT (CELL_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_valid (csr.valid),
      .csr_value (TICKS_W'(csr.payload)),
      .rsp_word  (rsp_word)
   );
endmodule

>>> rtl/eep_checker.sv
// Port-level checks of the data EEPROM controller, bound to its top level.
// Depends on eep_pkg and data_eeprom_controller.
module eep_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input eep_pkg::rsp_type rsp_payload
);
   // the erase sweep holds off the input right after reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input ready during erase sweep");

   // no word enters while a result sits untaken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
      else $error("word accepted over a pending result");

   // every rise of the result valid follows an accepted word, directly or after the cell read wait
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(req_valid && req_ready) || $past(req_valid && req_ready, 2)))
      else $error("result without an accepted word");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");
endmodule

bind data_eeprom_controller eep_checker u_eep_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
